// ----- sv/ple_pkg.sv -----
// ple_pkg: shared types and codes for the positional list engine
// command and response word structs, mode and status codes, cell operations
// no dependencies
package ple_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 8;
    localparam int LEN_W        = 6;
    localparam int MODE_W       = 3;
    localparam int STATUS_W     = 3;

    // operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_END   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_END   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd5;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } cmd_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    length;
    } rsp_word_t;

    // what every cell does at each clock edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [STATUS_W-1:0] status;
    } dec_t;

endpackage

// ----- sv/positional_list_engine.sv -----
// response: a response word is registered and appears in the cycle after its command word is taken
// throughput: one command word per cycle; the response register is refilled
//   in the cycle it is drained, so only a stalled response holds off commands
// reset: rst_n clears the list length and the response valid flag; slot
//   contents are not cleared, a slot is only read back after it was written
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ple_pkg::cmd_word_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ple_pkg::rsp_word_t rsp
);
    import ple_pkg::*;

    // count needs to hold CAPACITY itself
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_word_t        rsp_reg;
    rsp_word_t        rsp_next;

    dec_t             dec;
    logic [CNT_W-1:0] idx;
    logic             accept;
    cell_op_t         cell_op;

    // one row of slot values, slot 0 is the list front
    logic signed [VALUE_W-1:0] slot_data [CAPACITY];

    // a new command enters whenever the response register is free or draining
    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;

    ple_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .cmd        (cmd),
        .count      (count_reg),
        .dec        (dec),
        .idx        (idx),
        .count_next (count_next)
    );

    // cells only move on an accepted command
    assign cell_op = accept ? dec.op : CELL_HOLD;

    // the chain: every cell sees its left and right neighbor; the ends are tied
    // off, since an insert never pulls into slot 0 and a delete only vacates
    // the last slot
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_in;
        logic signed [VALUE_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_l
            assign left_in = slot_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = slot_data[i+1];
        end

        ple_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .idx        (idx),
            .value      (cmd.value),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (slot_data[i])
        );
    end

    // response word: status plus new length, length wraps into six bits
    always_comb
    begin
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        if (accept)
        begin
            rsp_next.status = dec.status;
            rsp_next.length = LEN_W'(count_next);
            rsp_valid_next  = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- sv/ple_cell.sv -----
// ple_cell: one storage slot of the list chain
// shifts toward or away from its neighbors, or loads the new value
// depends on ple_pkg
module ple_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic                                clk,
    input  ple_pkg::cell_op_t                   op,
    input  logic [CNT_W-1:0]                    idx,
    input  logic signed [ple_pkg::VALUE_W-1:0]  value,
    input  logic signed [ple_pkg::VALUE_W-1:0]  left_data,
    input  logic signed [ple_pkg::VALUE_W-1:0]  right_data,
    output logic signed [ple_pkg::VALUE_W-1:0]  data
);
    import ple_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_INSERT:
            begin
                if (MY_IDX > idx)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == idx)
                begin
                    data_next = value;
                end
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= idx)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- sv/ple_ctrl.sv -----
// ple_ctrl: decodes one command word against the current length
// gives status, the cell operation, the target slot and the new length
// depends on ple_pkg
module ple_ctrl #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  ple_pkg::cmd_word_t cmd,
    input  logic [CNT_W-1:0]   count,
    output ple_pkg::dec_t      dec,
    output logic [CNT_W-1:0]   idx,
    output logic [CNT_W-1:0]   count_next
);
    import ple_pkg::*;

    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic             full;
    logic             empty;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] cnt_w;
    logic [CNT_W-1:0] pos_idx;

    assign full    = (count == CAP_CNT);
    assign empty   = (count == '0);
    assign pos_w   = CMP_W'(cmd.position);
    assign cnt_w   = CMP_W'(count);
    // only used once the position is known to be within the list
    assign pos_idx = CNT_W'(pos_w - CMP_W'(1));

    always_comb
    begin
        dec.op     = CELL_HOLD;
        dec.status = ST_OK;
        idx        = '0;
        case (cmd.mode)
            MODE_INS_FRONT:
            begin
                if (full) dec.status = ST_FULL;
                else dec.op = CELL_INSERT;
            end
            MODE_INS_END:
            begin
                idx = count;
                if (full) dec.status = ST_FULL;
                else dec.op = CELL_INSERT;
            end
            MODE_INS_POS:
            begin
                idx = pos_idx;
                if (cmd.position == '0) dec.status = ST_BADPOS;
                else if (full) dec.status = ST_FULL;
                else if (pos_w > cnt_w + CMP_W'(1)) dec.status = ST_RANGE;
                else dec.op = CELL_INSERT;
            end
            MODE_DEL_FRONT:
            begin
                if (empty) dec.status = ST_EMPTY;
                else dec.op = CELL_DELETE;
            end
            MODE_DEL_END:
            begin
                idx = count - CNT_W'(1);
                if (empty) dec.status = ST_EMPTY;
                else dec.op = CELL_DELETE;
            end
            MODE_DEL_POS:
            begin
                idx = pos_idx;
                if (empty) dec.status = ST_EMPTY;
                else if (cmd.position == '0) dec.status = ST_BADPOS;
                else if (pos_w > cnt_w) dec.status = ST_RANGE;
                else dec.op = CELL_DELETE;
            end
            default:
            begin
                dec.op     = CELL_HOLD;
                dec.status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        case (dec.op)
            CELL_INSERT: count_next = count + CNT_W'(1);
            CELL_DELETE: count_next = count - CNT_W'(1);
            default:     count_next = count;
        endcase
    end

endmodule

// ----- sv/ple_checker.sv -----
// ple_checker: port-level assertions for the positional list engine
// bound to positional_list_engine; depends on ple_pkg
module ple_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input ple_pkg::cmd_word_t cmd,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input ple_pkg::rsp_word_t rsp
);
    import ple_pkg::*;

    // a waiting command word holds until taken
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("command word changed while waiting");

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // an accepted command always yields a response in the next cycle
    a_cmd_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> rsp_valid)
        else $error("accepted command gave no response");

    // with no pending response the engine must take commands
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> cmd_ready)
        else $error("command blocked with empty response register");

    // status is always a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_BADPOS ||
                       rsp.status == ST_RANGE || rsp.status == ST_EMPTY ||
                       rsp.status == ST_FULL))
        else $error("undefined status code");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
